>>> design/zzc_pkg.sv
package zzc_pkg;

    localparam int BUFFER_DEPTH = 4096;
    localparam int LEN_W        = 32;

    // request opcodes
    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_APPLY   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    // descriptor operations
    localparam logic [1:0] KOP_XOR  = 2'd0;
    localparam logic [1:0] KOP_ADD  = 2'd1;
    localparam logic [1:0] KOP_SUB  = 2'd2;
    localparam logic [1:0] KOP_ZERO = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  data_byte;
        logic [1:0]  key_operation;
        logic [7:0]  key_parameter;
        logic [31:0] key_length;
        logic [11:0] read_index;
    } t_request;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SWEEP,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [1:0] touch;
    } t_sweep;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] par;
        logic [7:0] twoq_low;
        logic       q_nz;
    } t_alu_ctrl;

endpackage

>>> design/xor_add_sub_zigzag_cipher.sv
// clear, load, restart and read requests, and apply on an empty buffer or with zero length:
// result strobe in the cycle after the request is taken, a new request every cycle
// apply otherwise: a serial division, then a read-modify-write sweep over every filled byte,
// then a drain state that lands the last write-back; busy stays high throughout and the
// result strobe rises as busy falls; results go out without back-pressure; synchronous
// active-low reset empties the buffer, restarts the walk and clears decrypt mode
module xor_add_sub_zigzag_cipher #(
    parameter int BUFFER_DEPTH = zzc_pkg::BUFFER_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  zzc_pkg::t_request i_request,
    output logic              o_result_valid,
    output zzc_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);

    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = FW + 1;
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = (FW > 12) ? FW : 12;

    zzc_pkg::t_state r_state, n_state;

    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_pos, n_pos;
    logic          r_back, n_back;
    logic          r_decrypt;
    logic [FW-1:0] r_idx, n_idx;
    logic [1:0]    r_op, n_op;
    logic [7:0]    r_par, n_par;
    logic [PW-1:0] r_s0, n_s0;
    logic [PW-1:0] r_period, n_period;
    logic          r_res_valid, n_res_valid;
    logic [1:0]    r_res_status, n_res_status;
    logic          r_res_read, n_res_read;

    logic                      accept;
    logic                      div_start;
    logic                      div_done;
    logic [zzc_pkg::LEN_W-1:0] div_quo;
    logic [PW-1:0]             div_rem;
    logic                      load_we;
    logic [AW-1:0]             rd_addr;
    logic [7:0]                rdata;
    zzc_pkg::t_sweep           sweep;
    zzc_pkg::t_alu_ctrl        alu;

    logic [FW-1:0] pos_norm;
    logic          back_norm;
    logic [1:0]    kop;
    logic [PW-1:0] ph_a, ph_b;
    logic [PW:0]   s1_sum;
    logic [PW-1:0] s1;

    // phase x falls in the walk window [s0, s0 + rem) taken modulo the period
    function automatic logic in_window(input logic [PW-1:0] x, input logic [PW-1:0] s0,
                                       input logic [PW-1:0] period, input logic [PW-1:0] rem);
        logic [PW:0] d;
        d = {1'b0, x} - {1'b0, s0};
        if (d[PW]) begin
            d = d + {1'b0, period};
        end
        return d[PW-1:0] < rem;
    endfunction

    assign accept      = start && !busy;
    assign busy        = (r_state != zzc_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == zzc_pkg::S_IDLE);

    zzc_div #(
        .DIVISOR_W (PW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_request.key_length),
        .i_divisor   (r_period),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    zzc_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDR_W       (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_we   (load_we),
        .i_load_addr (r_fill[AW-1:0]),
        .i_load_data (i_request.data_byte),
        .i_rd_addr   (rd_addr),
        .i_sweep     (sweep),
        .i_alu       (alu),
        .o_rdata     (rdata)
    );

    always_comb begin
        alu.op       = r_op;
        alu.par      = r_par;
        alu.twoq_low = {div_quo[6:0], 1'b0};
        alu.q_nz     = |div_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zzc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pos       <= '0;
            r_back      <= 1'b0;
            r_decrypt   <= 1'b0;
            r_res_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_back      <= n_back;
            r_res_valid <= n_res_valid;
            r_idx       <= n_idx;
            if (i_cfg_valid && o_cfg_ready) begin
                r_decrypt <= i_cfg_data;
            end
        end
        r_op         <= n_op;
        r_par        <= n_par;
        r_s0         <= n_s0;
        r_period     <= n_period;
        r_res_status <= n_res_status;
        r_res_read   <= n_res_read;
    end

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_pos        = r_pos;
        n_back       = r_back;
        n_idx        = r_idx;
        n_op         = r_op;
        n_par        = r_par;
        n_s0         = r_s0;
        n_period     = r_period;
        n_res_valid  = 1'b0;
        n_res_status = zzc_pkg::ST_OK;
        n_res_read   = 1'b0;
        div_start    = 1'b0;
        load_we      = 1'b0;
        sweep.valid  = 1'b0;
        sweep.touch  = 2'd0;
        rd_addr      = AW'(i_request.read_index);

        // walk left out of range restarts forward
        pos_norm  = (r_pos < r_fill) ? r_pos : '0;
        back_norm = (r_pos < r_fill) ? r_back : 1'b0;

        kop = i_request.key_operation;
        if (r_decrypt && kop == zzc_pkg::KOP_ADD) begin
            kop = zzc_pkg::KOP_SUB;
        end else if (r_decrypt && kop == zzc_pkg::KOP_SUB) begin
            kop = zzc_pkg::KOP_ADD;
        end

        ph_a = PW'(r_idx);
        ph_b = r_period - PW'(1) - PW'(r_idx);

        s1_sum = {1'b0, r_s0} + {1'b0, div_rem};
        if (s1_sum >= {1'b0, r_period}) begin
            s1_sum = s1_sum - {1'b0, r_period};
        end
        s1 = s1_sum[PW-1:0];

        unique case (r_state)
            zzc_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_valid = 1'b1;
                    case (i_request.opcode)
                        zzc_pkg::OP_CLEAR: begin
                            n_fill = '0;
                            n_pos  = '0;
                            n_back = 1'b0;
                        end
                        zzc_pkg::OP_LOAD: begin
                            if (r_fill < FW'(BUFFER_DEPTH)) begin
                                load_we = 1'b1;
                                n_fill  = r_fill + FW'(1);
                            end else begin
                                n_res_status = zzc_pkg::ST_FULL;
                            end
                        end
                        zzc_pkg::OP_RESTART: begin
                            n_pos  = '0;
                            n_back = 1'b0;
                        end
                        zzc_pkg::OP_APPLY: begin
                            if (r_fill == '0) begin
                                n_res_status = zzc_pkg::ST_EMPTY;
                            end else if (i_request.key_length != '0) begin
                                n_res_valid = 1'b0;
                                div_start   = 1'b1;
                                n_state     = zzc_pkg::S_DIV;
                                n_op        = kop;
                                n_par       = i_request.key_parameter;
                                n_period    = {r_fill, 1'b0};
                                n_s0        = back_norm ? (PW'(r_fill) + PW'(pos_norm))
                                                        : PW'(pos_norm);
                            end
                        end
                        zzc_pkg::OP_READ: begin
                            if (CW'(i_request.read_index) >= CW'(r_fill)) begin
                                n_res_status = zzc_pkg::ST_RANGE;
                            end else begin
                                n_res_read = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            zzc_pkg::S_DIV: begin
                if (div_done) begin
                    n_idx   = '0;
                    n_state = zzc_pkg::S_SWEEP;
                end
            end
            zzc_pkg::S_SWEEP: begin
                rd_addr     = r_idx[AW-1:0];
                sweep.valid = 1'b1;
                sweep.touch = {1'b0, in_window(ph_a, r_s0, r_period, div_rem)}
                            + {1'b0, in_window(ph_b, r_s0, r_period, div_rem)};
                if (r_idx == r_fill - FW'(1)) begin
                    n_state = zzc_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + FW'(1);
                end
            end
            zzc_pkg::S_DRAIN: begin
                // last write-back lands this cycle, walk moves on by the remainder
                n_state     = zzc_pkg::S_IDLE;
                n_res_valid = 1'b1;
                if (s1 >= PW'(r_fill)) begin
                    n_back = 1'b1;
                    n_pos  = FW'(s1 - PW'(r_fill));
                end else begin
                    n_back = 1'b0;
                    n_pos  = FW'(s1);
                end
            end
            default: begin
                n_state = zzc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_result_valid    = r_res_valid;
    assign o_result.out_byte = r_res_read ? rdata : 8'd0;
    assign o_result.status   = r_res_status;

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_request.opcode != zzc_pkg::OP_APPLY) |=> o_result_valid)
        else $error("single-cycle request gave no result");

    a_result_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while still busy");

    a_sweep_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == zzc_pkg::S_SWEEP) |-> (r_idx < r_fill))
        else $error("sweep index beyond fill");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == zzc_pkg::ST_EMPTY) |-> (r_fill == '0))
        else $error("empty status with bytes in the buffer");

    a_walk_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (r_pos < r_fill))
        else $error("walk position left outside fill after apply");

endmodule

>>> design/zzc_div.sv
module zzc_div #(
    parameter int DIVISOR_W = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [zzc_pkg::LEN_W-1:0]        i_dividend,
    input  logic [DIVISOR_W-1:0]             i_divisor,
    output logic                             o_done,
    output logic [zzc_pkg::LEN_W-1:0]        o_quotient,
    output logic [DIVISOR_W-1:0]             o_remainder
);

    localparam int CNT_W = $clog2(zzc_pkg::LEN_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [DIVISOR_W-1:0]      r_rem;
    logic [zzc_pkg::LEN_W-1:0] r_quo;

    logic [DIVISOR_W:0]        trial;
    logic [DIVISOR_W:0]        diff;
    logic                      fits;
    logic [DIVISOR_W-1:0]      n_rem;

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    always_comb begin
        trial = {r_rem, r_quo[zzc_pkg::LEN_W-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = (trial >= {1'b0, i_divisor});
        n_rem = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[zzc_pkg::LEN_W-2:0], fits};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(zzc_pkg::LEN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still iterating");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && r_cnt == '0))
        else $error("divider did not begin after start");

endmodule

>>> design/zzc_store.sv
module zzc_store #(
    parameter int BUFFER_DEPTH = zzc_pkg::BUFFER_DEPTH,
    parameter int ADDR_W       = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load_we,
    input  logic [ADDR_W-1:0]   i_load_addr,
    input  logic [7:0]          i_load_data,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    input  zzc_pkg::t_sweep     i_sweep,
    input  zzc_pkg::t_alu_ctrl  i_alu,
    output logic [7:0]          o_rdata
);

    logic [7:0]        mem [BUFFER_DEPTH];
    logic [7:0]        r_rdata;
    logic              r_sw_valid;
    logic [ADDR_W-1:0] r_sw_addr;
    logic [1:0]        r_touch;

    logic [7:0]        times_low;
    logic [15:0]       prod;
    logic              times_zero;
    logic [7:0]        new_byte;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    // the byte sees its op applied 2q + touch times in total
    always_comb begin
        times_low  = i_alu.twoq_low + {6'd0, r_touch};
        prod       = times_low * i_alu.par;
        times_zero = !i_alu.q_nz && (r_touch == 2'd0);
        case (i_alu.op)
            zzc_pkg::KOP_XOR: new_byte = r_touch[0] ? (r_rdata ^ i_alu.par) : r_rdata;
            zzc_pkg::KOP_ADD: new_byte = r_rdata + prod[7:0];
            zzc_pkg::KOP_SUB: new_byte = r_rdata - prod[7:0];
            default:          new_byte = times_zero ? r_rdata : 8'd0;
        endcase
        we    = i_load_we || r_sw_valid;
        waddr = r_sw_valid ? r_sw_addr : i_load_addr;
        wdata = r_sw_valid ? new_byte : i_load_data;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_rd_addr];
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_valid <= 1'b0;
        end else begin
            r_sw_valid <= i_sweep.valid;
        end
        r_sw_addr <= i_rd_addr;
        r_touch   <= i_sweep.touch;
    end

    assign o_rdata = r_rdata;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sw_valid |-> !i_load_we)
        else $error("load write collides with sweep write-back");

    a_sweep_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sweep.valid |=> r_sw_valid)
        else $error("sweep read not followed by write-back");

    a_no_touch_past_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sw_valid |-> (r_touch != 2'd3))
        else $error("byte touched more than twice in one window");

endmodule
